// ----- hw/rtl/fkpd_pkg.sv -----
// Shared types and constants for the four-key short/long press detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fkpd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned KeysW  = 4;
  localparam int unsigned EventW = 4;
  localparam int unsigned KeyIdW = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_CONTINUOUS = 2'd0;
  localparam logic [1:0] REG_SCAN_INT   = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS = 2'd2;

  // Held key codes and event codes.
  localparam logic [KeyIdW-1:0] NO_KEY     = 3'd0;
  localparam logic [KeyIdW-1:0] KEY_1      = 3'd1;
  localparam logic [KeyIdW-1:0] KEY_2      = 3'd2;
  localparam logic [KeyIdW-1:0] KEY_3      = 3'd3;
  localparam logic [KeyIdW-1:0] KEY_4      = 3'd4;
  localparam logic [EventW-1:0] EV_NONE    = 4'd0;
  localparam logic [EventW-1:0] EV_LONG_OFS = 4'd4;

  typedef struct packed {
    logic        continuous_mode;
    logic [9:0]  scan_period;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [KeysW-1:0] key_levels;
    logic             event_taken;
  } item_t;

  typedef struct packed {
    logic [EventW-1:0] pending_event;
    logic              long_led;
    logic              short_led;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fkpd_cfg.sv -----
// Configuration register bank of the press detector.
// Depends on fkpd_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module fkpd_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output fkpd_pkg::cfg_t     cfg
);
  import fkpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.continuous_mode <= 1'b0;
      cfg.scan_period     <= 10'd10;
      cfg.long_press_ms   <= 16'd1000;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONTINUOUS: cfg.continuous_mode <= wr_data[0];
        REG_SCAN_INT:   cfg.scan_period     <= wr_data[9:0];
        REG_LONG_PRESS: cfg.long_press_ms   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fkpd_step.sv -----
// Scan state of the press detector and the logic that advances it by one beat.
// Depends on fkpd_pkg; the result is the state as it stands after the beat.
`default_nettype none

module fkpd_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire fkpd_pkg::cfg_t    cfg,
  input  wire fkpd_pkg::item_t   item,
  output fkpd_pkg::result_t      result
);
  import fkpd_pkg::*;

  logic [TimeW-1:0]  scan_stamp, scan_stamp_next;
  logic [TimeW-1:0]  press_start_time, press_start_time_next;
  logic [KeyIdW-1:0] held_key, held_key_next;
  logic              released_flag, released_flag_next;
  logic [EventW-1:0] event_store, event_store_next;
  logic              long_led_level, long_led_level_next;
  logic              short_led_level, short_led_level_next;

  logic [TimeW-1:0]  since_scan;
  logic [TimeW-1:0]  dur;
  logic              scan_due;
  logic              rel_eff;
  logic              any_key;
  logic              held_valid;
  logic [1:0]        held_m1;
  logic [KeyIdW-1:0] first_key;
  logic              long_hit;
  logic [EventW-1:0] ev_cleared;

  assign since_scan = item.now_ms - scan_stamp;
  assign scan_due   = since_scan >= {22'd0, cfg.scan_period};
  assign dur        = item.now_ms - press_start_time;
  assign rel_eff    = released_flag | cfg.continuous_mode;
  assign any_key    = |item.key_levels;
  assign held_valid = held_key != NO_KEY;
  assign held_m1    = held_key[1:0] - 2'd1;
  assign long_hit   = dur >= {16'd0, cfg.long_press_ms};
  assign ev_cleared = item.event_taken ? EV_NONE : event_store;

  always_comb begin
    if (item.key_levels[0])      first_key = KEY_1;
    else if (item.key_levels[1]) first_key = KEY_2;
    else if (item.key_levels[2]) first_key = KEY_3;
    else                         first_key = KEY_4;
  end

  always_comb begin
    scan_stamp_next       = scan_stamp;
    press_start_time_next = press_start_time;
    held_key_next         = held_key;
    released_flag_next    = released_flag;
    event_store_next      = ev_cleared;
    long_led_level_next   = long_led_level;
    short_led_level_next  = short_led_level;
    if (scan_due) begin
      scan_stamp_next    = item.now_ms;
      released_flag_next = rel_eff;
      if (rel_eff && any_key) begin
        // Fresh press: latch the highest-priority key and its start time.
        released_flag_next    = 1'b0;
        held_key_next         = first_key;
        press_start_time_next = item.now_ms;
      end else if (any_key) begin
        if (held_valid && long_hit && item.key_levels[held_m1]) begin
          if (ev_cleared == EV_NONE) begin
            event_store_next = EV_LONG_OFS + {1'b0, held_key};
          end
          long_led_level_next = ~long_led_level;
          // Keys 1 and 4 report a long press once only.
          if (held_key == KEY_1 || held_key == KEY_4) begin
            held_key_next = NO_KEY;
          end
        end
      end else begin
        released_flag_next = 1'b1;
        if (held_valid && !long_hit) begin
          if (ev_cleared == EV_NONE) begin
            event_store_next = {1'b0, held_key};
          end
          short_led_level_next = ~short_led_level;
        end
        held_key_next = NO_KEY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_stamp       <= '0;
      press_start_time <= '0;
      held_key         <= NO_KEY;
      released_flag    <= 1'b1;
      event_store      <= EV_NONE;
      long_led_level   <= 1'b0;
      short_led_level  <= 1'b0;
    end else if (fire) begin
      scan_stamp       <= scan_stamp_next;
      press_start_time <= press_start_time_next;
      held_key         <= held_key_next;
      released_flag    <= released_flag_next;
      event_store      <= event_store_next;
      long_led_level   <= long_led_level_next;
      short_led_level  <= short_led_level_next;
    end
  end

  assign result.pending_event = event_store_next;
  assign result.long_led      = long_led_level_next;
  assign result.short_led     = short_led_level_next;

endmodule

`default_nettype wire

// ----- hw/rtl/four_key_short_long_press_detector_unit.sv -----
// Four-key short/long press detector: one result beat for every input beat.
// An accepted input beat goes through the input register, then the result register;
// one beat is accepted per cycle while m_tready stays high.
// Reset (rst, synchronous, active high) empties both pipeline registers, loads the
// configuration defaults and returns the scan state to no key held, no event.
// Depends on fkpd_pkg, fkpd_cfg and fkpd_step.
`default_nettype none

module four_key_short_long_press_detector_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [31:0] now_ms, [35:32] key_levels,
                                      // [36] event_taken, [39:37] zero
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [3:0] pending_event, [4] long_led,
                                      // [5] short_led, [7:6] zero
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import fkpd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t step_result;
  result_t out_result;

  // Configuration writes are always taken; the bank keeps only each register's width.
  assign cfg_ready = 1'b1;

  fkpd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The step fires when the input register holds a beat and the result register
  // is free or is being emptied in this cycle. The input register in turn
  // takes a new beat whenever it is empty or its beat moves on, so a result
  // waiting at the output does not stop one more beat from being accepted.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.now_ms      <= s_tdata[31:0];
      in_item.key_levels  <= s_tdata[35:32];
      in_item.event_taken <= s_tdata[36];
    end
  end

  // The scan state lives in the step unit and is updated in the same cycle
  // as the result is formed, so consecutive beats see each other's effects.
  fkpd_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cfg    (cfg),
    .item   (in_item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {2'b00, out_result.short_led, out_result.long_led,
                    out_result.pending_event};

endmodule

`default_nettype wire
